>>> design/sbus_frame_receiver_macros.svh
// assertion macros used by the sbus frame receiver queue module
`ifndef SBUS_FRAME_RECEIVER_MACROS_SVH
`define SBUS_FRAME_RECEIVER_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define SFR_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `SFR_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

>>> design/sfr_pkg.sv
// types and constants of the sbus frame receiver
`default_nettype none
package sfr_pkg;

  localparam int PAYLOAD_BYTES = 23;
  localparam int NUM_CH        = 16;
  localparam int CH_BITS       = 11;
  localparam int CH_DATA_BITS  = NUM_CH * CH_BITS;
  localparam int CH_DATA_BYTES = CH_DATA_BITS / 8;
  localparam int COUNT_W       = $clog2(PAYLOAD_BYTES + 1);
  localparam int INDEX_W       = $clog2(PAYLOAD_BYTES);
  localparam int CH_IDX_W      = $clog2(NUM_CH);
  localparam int QUEUE_DEPTH   = 2;
  localparam int PTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HDR_BYTE = 8'h0F;
  localparam logic [7:0] FTR_BYTE = 8'h00;

  localparam int FLAG_BIT_A  = 7;
  localparam int FLAG_BIT_B  = 6;
  localparam int FLAG_BIT_FS = 4;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_FOOT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0]              flags;
    logic [CH_DATA_BITS-1:0] bits;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

>>> design/sbus_frame_receiver.sv
// sbus frame receiver: byte parser, frame queue and channel sequencer
// the first channel result of a frame passes the frame queue and the output register after the footer transaction
// throughput: one byte per cycle in while not stalled; sixteen results per frame, one per cycle
// while out_stall is low, set by the channel sequencer stepping through the queued frame
// input stalls only while both frame queue entries are occupied
// reset: synchronous, active high; parser idle, queue empty, no result pending
`default_nettype none
module sbus_frame_receiver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [sfr_pkg::CH_IDX_W-1:0] channel_index,
  output logic [sfr_pkg::CH_BITS-1:0]  channel_value,
  output logic                         digital_a,
  output logic                         digital_b,
  output logic                         failsafe_active,
  output logic                         last_of_frame
);
  import sfr_pkg::*;

  queue_status_t status;
  frame_t        push_frame;
  frame_t        head;
  logic          push;
  logic          pop;

  sfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .status   (status),
    .push     (push),
    .frame    (push_frame)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  sfr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .status          (status),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_a       (digital_a),
    .digital_b       (digital_b),
    .failsafe_active (failsafe_active),
    .last_of_frame   (last_of_frame)
  );

endmodule
`default_nettype wire

>>> design/sfr_front.sv
// byte parser: header, payload capture and footer detection
`default_nettype none
module sfr_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            rx_byte,
  input  sfr_pkg::queue_status_t status,
  output logic                  push,
  output sfr_pkg::frame_t       frame
);
  import sfr_pkg::*;

  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [7:0]         store [PAYLOAD_BYTES];
  logic               accept;
  logic               store_we;

  assign in_stall = status.full;
  assign accept   = in_valid && !status.full;

  always_comb begin
    phase_next = phase;
    count_next = count;
    push       = 1'b0;
    store_we   = 1'b0;
    if (accept) begin
      case (phase)
        PH_DATA: begin
          store_we   = 1'b1;
          count_next = count + COUNT_W'(1);
          if (count_next >= COUNT_W'(PAYLOAD_BYTES)) begin
            phase_next = PH_FOOT;
          end
        end
        PH_FOOT: begin
          // any other byte is dropped while waiting for the footer
          if (rx_byte == FTR_BYTE) begin
            push       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (rx_byte == HDR_BYTE) begin
            phase_next = PH_DATA;
            count_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      count <= '0;
    end else begin
      phase <= phase_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[count[INDEX_W-1:0]] <= rx_byte;
    end
  end

  // little-endian bit stream of the channel bytes
  always_comb begin
    for (int i = 0; i < CH_DATA_BYTES; i++) begin
      frame.bits[8*i +: 8] = store[i];
    end
    frame.flags = store[PAYLOAD_BYTES-1];
  end

endmodule
`default_nettype wire

>>> design/sfr_queue.sv
// short frame queue between parser and channel sequencer
`default_nettype none
module sfr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  sfr_pkg::frame_t        push_frame,
  input  logic                   pop,
  output sfr_pkg::frame_t        head,
  output sfr_pkg::queue_status_t status
);
  import sfr_pkg::*;
  `include "sbus_frame_receiver_macros.svh"

  frame_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign status.full  = (count == QCOUNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCOUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_frame;
    end
  end

  `SFR_ASSERT_NEVER(a_no_push_full, clk, rst, push && status.full, "push into full queue")
  `SFR_ASSERT_NEVER(a_no_pop_empty, clk, rst, pop && status.empty, "pop from empty queue")
  `SFR_ASSERT(a_count_range, clk, rst, count <= QCOUNT_W'(QUEUE_DEPTH), "queue count overrun")
  `SFR_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + QCOUNT_W'(1)), "queue count lost a push")

endmodule
`default_nettype wire

>>> design/sfr_back.sv
// channel sequencer: unpacks one channel per cycle into the output register while it is free or being taken
`default_nettype none
module sfr_back (
  input  logic                             clk,
  input  logic                             rst,
  input  sfr_pkg::frame_t                  head,
  input  sfr_pkg::queue_status_t           status,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sfr_pkg::CH_IDX_W-1:0]     channel_index,
  output logic [sfr_pkg::CH_BITS-1:0]      channel_value,
  output logic                             digital_a,
  output logic                             digital_b,
  output logic                             failsafe_active,
  output logic                             last_of_frame
);
  import sfr_pkg::*;

  localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);

  logic [CH_IDX_W-1:0] ch;
  logic                load;
  logic                issue;

  // output register free or its transaction completes this cycle
  assign load  = !out_valid || !out_stall;
  assign issue = load && !status.empty;
  assign pop   = issue && (ch == LAST_CH);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ch        <= '0;
    end else begin
      if (load) begin
        out_valid <= !status.empty;
      end
      if (issue) begin
        ch <= (ch == LAST_CH) ? '0 : ch + CH_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      channel_index   <= ch;
      channel_value   <= head.bits[ch*CH_BITS +: CH_BITS];
      digital_a       <= head.flags[FLAG_BIT_A];
      digital_b       <= head.flags[FLAG_BIT_B];
      failsafe_active <= head.flags[FLAG_BIT_FS];
      last_of_frame   <= (ch == LAST_CH);
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/sbus_frame_checker.sv
// channel result predictor and scoreboard for the sbus frame receiver
module sbus_frame_checker
  import sfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [CH_IDX_W-1:0] channel_index,
  input  logic [CH_BITS-1:0]  channel_value,
  input  logic                digital_a,
  input  logic                digital_b,
  input  logic                failsafe_active,
  input  logic                last_of_frame,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [CH_IDX_W-1:0] ch_index;
    logic [CH_BITS-1:0]  ch_value;
    logic                dig_a;
    logic                dig_b;
    logic                fs;
    logic                last_flag;
  } channel_result_t;

  channel_result_t expected_channels[$];

  // decoder state as seen from the byte stream
  phase_t     parse_phase;
  logic [4:0] payload_count;
  logic [7:0] payload_store [PAYLOAD_BYTES];
  logic       failsafe_flag;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_PRINTED)
      $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // advance the decoder by one byte and queue the channels of a finished frame
  task automatic decode_byte(input logic [7:0] data);
    channel_result_t              r;
    logic [CH_DATA_BITS-1:0]      bits;
    logic [7:0]                   flags;
    int                           i;
    int                           k;
    case (parse_phase)
      PH_DATA: begin
        if (payload_count < PAYLOAD_BYTES)
          payload_store[payload_count] = data;
        payload_count = payload_count + 5'd1;
        if (payload_count >= PAYLOAD_BYTES)
          parse_phase = PH_FOOT;
      end
      PH_FOOT: begin
        // anything but the footer is dropped here
        if (data == FTR_BYTE) begin
          parse_phase   = PH_IDLE;
          flags         = payload_store[PAYLOAD_BYTES-1];
          failsafe_flag = flags[FLAG_BIT_FS];
          for (i = 0; i < CH_DATA_BYTES; i++)
            bits[8*i +: 8] = payload_store[i];
          for (k = 0; k < NUM_CH; k++) begin
            r.ch_index  = k[CH_IDX_W-1:0];
            r.ch_value  = bits[CH_BITS*k +: CH_BITS];
            r.dig_a     = flags[FLAG_BIT_A];
            r.dig_b     = flags[FLAG_BIT_B];
            r.fs        = failsafe_flag;
            r.last_flag = (k == NUM_CH - 1);
            expected_channels.push_back(r);
          end
        end
      end
      default: begin
        // idle and the unused phase code both hunt for a header
        parse_phase = PH_IDLE;
        if (data == HDR_BYTE) begin
          parse_phase   = PH_DATA;
          payload_count = '0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    channel_result_t want;
    if (rst) begin
      parse_phase   = PH_IDLE;
      payload_count = '0;
      failsafe_flag = 1'b1;
      expected_channels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_channels.size() == 0) begin
          report_mismatch($sformatf("unexpected result for channel %0d", channel_index));
        end else begin
          want = expected_channels.pop_front();
          check_field("channel_index", 16'(channel_index), 16'(want.ch_index));
          check_field("channel_value", 16'(channel_value), 16'(want.ch_value));
          check_field("digital_a", 16'(digital_a), 16'(want.dig_a));
          check_field("digital_b", 16'(digital_b), 16'(want.dig_b));
          check_field("failsafe_active", 16'(failsafe_active), 16'(want.fs));
          check_field("last_of_frame", 16'(last_of_frame), 16'(want.last_flag));
        end
      end
      if (in_valid && !in_stall)
        decode_byte(rx_byte);
    end
    pending = expected_channels.size();
  end

endmodule

>>> tb/sv/tb.sv
// testbench top: byte stimulus, result sink and verdict for the sbus frame receiver
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfr_pkg::*;

  localparam int ITEM_TARGET      = 310;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 40;
  localparam int FRAME_ITEMS      = PAYLOAD_BYTES + 2;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [7:0]          rx_byte   = 8'h00;
  logic                out_stall = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [CH_IDX_W-1:0] channel_index;
  logic [CH_BITS-1:0]  channel_value;
  logic                digital_a;
  logic                digital_b;
  logic                failsafe_active;
  logic                last_of_frame;
  int                  fail_count;
  int                  pending;

  // raised by the byte source, served by the result sink
  bit long_hold_req = 1'b0;
  int send_mode     = 2;

  always #5 clk = ~clk;

  sbus_frame_receiver uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_a       (digital_a),
    .digital_b       (digital_b),
    .failsafe_active (failsafe_active),
    .last_of_frame   (last_of_frame)
  );

  sbus_frame_checker chk (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .rx_byte         (rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .channel_index   (channel_index),
    .channel_value   (channel_value),
    .digital_a       (digital_a),
    .digital_b       (digital_b),
    .failsafe_active (failsafe_active),
    .last_of_frame   (last_of_frame),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // mode 0 never idles, mode 1 idles briefly, others up to the full range
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_frame();
    int fill;
    int i;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    send_byte(HDR_BYTE);
    fill = $urandom_range(0, 7);
    for (i = 0; i < PAYLOAD_BYTES; i++)
      send_byte(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
    // junk between payload and footer must be skipped
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
    // now and then the footer goes missing
    if ($urandom_range(0, 9) != 0)
      send_byte(FTR_BYTE);
  endtask

  initial begin : byte_source
    int i;
    int frame_items;
    int fnum;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed frame: idle junk, header inside payload, all-ones channels apart from channel 0,
    // flag bits set, a non-footer byte after the payload
    send_byte(8'hFF);
    send_byte(FTR_BYTE);
    send_byte(HDR_BYTE);
    send_byte(HDR_BYTE);
    for (i = 1; i < PAYLOAD_BYTES - 1; i++)
      send_byte(8'hFF);
    send_byte(8'hD0);
    send_byte(HDR_BYTE);
    send_byte(FTR_BYTE);

    frame_items = FRAME_ITEMS;
    fnum = 0;
    while (frame_items < ITEM_TARGET) begin
      send_mode = $urandom_range(0, 3);
      if (fnum == 4)
        long_hold_req = 1'b1;
      // keep the input busy while the sink holds off
      if (fnum >= 4 && fnum < 8)
        send_mode = 0;
      send_random_frame();
      frame_items += FRAME_ITEMS;
      fnum++;
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin : result_sink
    int hold;
    int taken;
    int mode;
    taken = 0;
    mode  = 0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end
      if (taken % NUM_CH == 0)
        mode = $urandom_range(0, 3);
      hold = draw_gap(mode);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
